[sv/esv_pkg.sv]
package esv_pkg;

    // Operand width of the modular datapath
    localparam int W = 16;
    localparam int CNT_BITS = $clog2(W + 1);

    // Store for the distinct prime factors of p-1
    localparam int FAC_DEPTH = 8;
    localparam int FAC_IDX_BITS = $clog2(FAC_DEPTH);
    localparam int NF_BITS = FAC_IDX_BITS + 1;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_ROOT = 2'd1;
    localparam logic [1:0] STAT_NO_INV  = 2'd2;

    // Configuration register indexes
    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_PRIVKEY = 1'b1;

    typedef enum logic {
        OP_DIV,
        OP_MULMOD
    } esv_op_t;

    typedef struct packed {
        logic           start;
        esv_op_t        op;
        logic [W-1:0]   a;
        logic [W-1:0]   b;
        logic [W-1:0]   n;
    } esv_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [W-1:0]   quot;
        logic [W-1:0]   rem;
    } esv_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PCHK,
        ST_PWAIT,
        ST_FCHK,
        ST_FWAIT,
        ST_RA,
        ST_RK,
        ST_RDIV,
        ST_RTEST,
        ST_GOT_E2,
        ST_GOT_S1,
        ST_RWAIT,
        ST_INV,
        ST_DM0,
        ST_DM1,
        ST_CAL,
        ST_S2,
        ST_GOT_V1,
        ST_GOT_V2A,
        ST_GOT_V2B,
        ST_VWAIT,
        ST_POW,
        ST_PMUL,
        ST_PSQ,
        ST_FINISH
    } esv_state_t;

endpackage

[sv/esv_modunit.sv]
// Shared modular unit, one operand bit per cycle, MSB first.
// OP_DIV:    b / n, giving quotient and remainder (restoring division).
// OP_MULMOD: (a * b) mod n, with a already below n.
module esv_modunit (
    input  logic              clk,
    input  logic              rst_n,
    input  esv_pkg::esv_req_t req,
    output esv_pkg::esv_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [esv_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    esv_pkg::esv_op_t              op_reg, op_next;
    logic [esv_pkg::W-1:0]         a_reg, a_next;
    logic [esv_pkg::W-1:0]         n_reg, n_next;
    logic [esv_pkg::W-1:0]         sh_reg, sh_next;
    logic [esv_pkg::W-1:0]         acc_reg, acc_next;
    logic [esv_pkg::W-1:0]         quot_reg, quot_next;

    logic [esv_pkg::W+1:0]         addend;
    logic [esv_pkg::W+1:0]         t0, t1, t2;
    logic [esv_pkg::W+1:0]         n_ext;
    logic                          qbit;

    // Shift in one bit and reduce by at most two subtractions
    always_comb
    begin
        n_ext = {2'b00, n_reg};
        if (op_reg == esv_pkg::OP_DIV)
        begin
            addend = {{(esv_pkg::W+1){1'b0}}, sh_reg[esv_pkg::W-1]};
        end
        else
        begin
            addend = sh_reg[esv_pkg::W-1] ? {2'b00, a_reg} : '0;
        end
        t0   = {1'b0, acc_reg, 1'b0} + addend;
        qbit = (t0 >= n_ext);
        t1   = qbit ? (t0 - n_ext) : t0;
        t2   = (t1 >= n_ext) ? (t1 - n_ext) : t1;
    end

    // Load on request, then step until the count runs out
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        n_next    = n_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        quot_next = quot_reg;
        if (busy_reg)
        begin
            acc_next  = t2[esv_pkg::W-1:0];
            quot_next = {quot_reg[esv_pkg::W-2:0], qbit};
            sh_next   = {sh_reg[esv_pkg::W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == esv_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = esv_pkg::CNT_BITS'(esv_pkg::W);
            op_next   = req.op;
            a_next    = req.a;
            n_next    = req.n;
            sh_next   = req.b;
            acc_next  = '0;
            quot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        n_reg    <= n_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = acc_reg;

endmodule

[sv/elgamal_sign_and_verify.sv]
// Channel   Ports                                         Direction  Handshake
// config    psel penable pwrite paddr pwdata prdata pready in/out    APB, pready tied high
// command   start message_value nonce_value busy          in         start while busy low
// result    done generator public_key sig_first            out        done for one cycle
//           sig_second verified status
//
// One item is a long sequence: every modular multiply or divide runs through the shared
// unit, and the primality and factor trial divisions, the root search (one exponentiation
// per prime factor of p-1 and candidate) and five further exponentiations are sequenced
// through it; the inverse search over candidates up to p-1 does not use the unit.
// Reset (rst_n low, asynchronous) loads p = 3119 and d = 127 and idles the sequencer.
// busy stays high from acceptance through the done cycle; results cannot be stalled.
module elgamal_sign_and_verify (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] message_value,
    input  logic [15:0] nonce_value,
    output logic        done,
    output logic [15:0] generator,
    output logic [15:0] public_key,
    output logic [15:0] sig_first,
    output logic [15:0] sig_second,
    output logic        verified,
    output logic [1:0]  status
);

    localparam int W = esv_pkg::W;

    esv_pkg::esv_state_t state_reg, state_next;
    esv_pkg::esv_state_t ret_reg, ret_next;

    logic [W-1:0] p_cfg_reg, d_cfg_reg;
    logic [W-1:0] m_reg, m_next, r_reg, r_next;
    logic [W-1:0] q_reg, q_next, rest_reg, rest_next;
    logic         first_reg, first_next;
    logic [W-1:0] fac_reg [esv_pkg::FAC_DEPTH];
    logic [W-1:0] fac_wdata;
    logic         fac_we;
    logic [esv_pkg::NF_BITS-1:0] nf_reg, nf_next, k_reg, k_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] e1_reg, e1_next, e2_reg, e2_next, s1_reg, s1_next, s2_reg, s2_next;
    logic         ver_reg, ver_next;
    logic [1:0]   stat_reg, stat_next;
    logic [W-1:0] rn_reg, rn_next, inv_reg, inv_next, prod_reg, prod_next;
    logic [W-1:0] tmp_reg, tmp_next, v1_reg, v1_next, v2a_reg, v2a_next;
    logic [W-1:0] pw_base_reg, pw_base_next, pw_exp_reg, pw_exp_next;
    logic [W-1:0] pw_acc_reg, pw_acc_next;

    esv_pkg::esv_req_t req;
    esv_pkg::esv_rsp_t rsp;

    logic            accept;
    logic            cfg_wr;
    logic [W-1:0]    nm1;
    logic [2*W-1:0]  q_sq;
    logic            q_sq_gt_p, q_sq_gt_rest;
    logic [W:0]      prod_sum, cal_w;
    logic [W-1:0]    prod_add, cal;
    logic [W-1:0]    fac_k;

    esv_modunit u_modunit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Configuration port
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == esv_pkg::REG_MODULUS) ? {16'd0, p_cfg_reg} : {16'd0, d_cfg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_cfg_reg <= 16'd3119;
            d_cfg_reg <= 16'd127;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == esv_pkg::REG_MODULUS)
            begin
                p_cfg_reg <= pwdata[15:0];
            end
            else
            begin
                d_cfg_reg <= pwdata[15:0];
            end
        end
    end

    // Shared helper terms
    assign accept       = start & ~busy;
    assign nm1          = p_cfg_reg - 1'b1;
    assign q_sq         = {{W{1'b0}}, q_reg} * {{W{1'b0}}, q_reg};
    assign q_sq_gt_p    = q_sq > {{W{1'b0}}, p_cfg_reg};
    assign q_sq_gt_rest = q_sq > {{W{1'b0}}, rest_reg};
    assign prod_sum     = {1'b0, prod_reg} + {1'b0, rn_reg};
    assign prod_add     = (prod_sum >= {1'b0, nm1}) ? W'(prod_sum - {1'b0, nm1})
                                                     : prod_sum[W-1:0];
    assign cal_w        = (rsp.rem >= tmp_reg) ? ({1'b0, rsp.rem} - {1'b0, tmp_reg})
                                               : ({1'b0, rsp.rem} + {1'b0, nm1} - {1'b0, tmp_reg});
    assign cal          = cal_w[W-1:0];
    assign fac_k        = fac_reg[k_reg[esv_pkg::FAC_IDX_BITS-1:0]];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esv_pkg::ST_IDLE:    if (accept) state_next = esv_pkg::ST_PCHK;
            esv_pkg::ST_PCHK:
            begin
                if (p_cfg_reg < 16'd3)  state_next = esv_pkg::ST_FINISH;
                else if (q_sq_gt_p)     state_next = esv_pkg::ST_FCHK;
                else                    state_next = esv_pkg::ST_PWAIT;
            end
            esv_pkg::ST_PWAIT:
                if (rsp.done) state_next = (rsp.rem == '0) ? esv_pkg::ST_FINISH : esv_pkg::ST_PCHK;
            esv_pkg::ST_FCHK:
                state_next = q_sq_gt_rest ? esv_pkg::ST_RA : esv_pkg::ST_FWAIT;
            esv_pkg::ST_FWAIT:
                if (rsp.done && rsp.rem != '0) state_next = esv_pkg::ST_FCHK;
            esv_pkg::ST_RA:
                state_next = (a_reg >= p_cfg_reg) ? esv_pkg::ST_FINISH : esv_pkg::ST_RK;
            esv_pkg::ST_RK:
                state_next = (k_reg == nf_reg) ? esv_pkg::ST_POW : esv_pkg::ST_RDIV;
            esv_pkg::ST_RDIV:    if (rsp.done) state_next = esv_pkg::ST_POW;
            esv_pkg::ST_RTEST:
                state_next = (pw_acc_reg == W'(1)) ? esv_pkg::ST_RA : esv_pkg::ST_RK;
            esv_pkg::ST_GOT_E2:  state_next = esv_pkg::ST_POW;
            esv_pkg::ST_GOT_S1:  state_next = esv_pkg::ST_RWAIT;
            esv_pkg::ST_RWAIT:   if (rsp.done) state_next = esv_pkg::ST_INV;
            esv_pkg::ST_INV:
            begin
                if (prod_reg == W'(1))  state_next = esv_pkg::ST_DM0;
                else if (inv_reg == nm1) state_next = esv_pkg::ST_FINISH;
            end
            esv_pkg::ST_DM0:     if (rsp.done) state_next = esv_pkg::ST_DM1;
            esv_pkg::ST_DM1:     if (rsp.done) state_next = esv_pkg::ST_CAL;
            esv_pkg::ST_CAL:     if (rsp.done) state_next = esv_pkg::ST_S2;
            esv_pkg::ST_S2:      if (rsp.done) state_next = esv_pkg::ST_POW;
            esv_pkg::ST_GOT_V1:  state_next = esv_pkg::ST_POW;
            esv_pkg::ST_GOT_V2A: state_next = esv_pkg::ST_POW;
            esv_pkg::ST_GOT_V2B: state_next = esv_pkg::ST_VWAIT;
            esv_pkg::ST_VWAIT:   if (rsp.done) state_next = esv_pkg::ST_FINISH;
            esv_pkg::ST_POW:
            begin
                if (pw_exp_reg == '0)   state_next = ret_reg;
                else if (pw_exp_reg[0]) state_next = esv_pkg::ST_PMUL;
                else                    state_next = esv_pkg::ST_PSQ;
            end
            esv_pkg::ST_PMUL:    if (rsp.done) state_next = esv_pkg::ST_PSQ;
            esv_pkg::ST_PSQ:     if (rsp.done) state_next = esv_pkg::ST_POW;
            esv_pkg::ST_FINISH:  state_next = esv_pkg::ST_IDLE;
            default:             state_next = esv_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates and unit requests
    always_comb
    begin
        ret_next     = ret_reg;
        m_next       = m_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        rest_next    = rest_reg;
        first_next   = first_reg;
        fac_we       = 1'b0;
        fac_wdata    = q_reg;
        nf_next      = nf_reg;
        k_next       = k_reg;
        a_next       = a_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        ver_next     = ver_reg;
        stat_next    = stat_reg;
        rn_next      = rn_reg;
        inv_next     = inv_reg;
        prod_next    = prod_reg;
        tmp_next     = tmp_reg;
        v1_next      = v1_reg;
        v2a_next     = v2a_reg;
        pw_base_next = pw_base_reg;
        pw_exp_next  = pw_exp_reg;
        pw_acc_next  = pw_acc_reg;
        req.start    = 1'b0;
        req.op       = esv_pkg::OP_DIV;
        req.a        = '0;
        req.b        = '0;
        req.n        = p_cfg_reg;

        unique case (state_reg)
            esv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    m_next    = message_value;
                    r_next    = nonce_value;
                    q_next    = W'(2);
                    e1_next   = '0;
                    e2_next   = '0;
                    s1_next   = '0;
                    s2_next   = '0;
                    ver_next  = 1'b0;
                    stat_next = esv_pkg::STAT_OK;
                end
            end
            // Trial division for primality
            esv_pkg::ST_PCHK:
            begin
                if (p_cfg_reg < 16'd3)
                begin
                    stat_next = esv_pkg::STAT_NO_ROOT;
                end
                else if (q_sq_gt_p)
                begin
                    rest_next = nm1;
                    q_next    = W'(2);
                    nf_next   = '0;
                end
                else
                begin
                    req.start = 1'b1;
                    req.b     = p_cfg_reg;
                    req.n     = q_reg;
                end
            end
            esv_pkg::ST_PWAIT:
            begin
                if (rsp.done)
                begin
                    if (rsp.rem == '0) stat_next = esv_pkg::STAT_NO_ROOT;
                    else               q_next = q_reg + 1'b1;
                end
            end
            // Factor p-1 into its distinct primes
            esv_pkg::ST_FCHK:
            begin
                if (q_sq_gt_rest)
                begin
                    if (rest_reg > W'(1))
                    begin
                        fac_we    = 1'b1;
                        fac_wdata = rest_reg;
                        nf_next   = nf_reg + 1'b1;
                    end
                    a_next = W'(2);
                end
                else
                begin
                    req.start  = 1'b1;
                    req.b      = rest_reg;
                    req.n      = q_reg;
                    first_next = 1'b1;
                end
            end
            esv_pkg::ST_FWAIT:
            begin
                if (rsp.done)
                begin
                    if (rsp.rem == '0)
                    begin
                        if (first_reg)
                        begin
                            fac_we  = 1'b1;
                            nf_next = nf_reg + 1'b1;
                        end
                        first_next = 1'b0;
                        rest_next  = rsp.quot;
                        req.start  = 1'b1;
                        req.b      = rsp.quot;
                        req.n      = q_reg;
                    end
                    else
                    begin
                        q_next = q_reg + 1'b1;
                    end
                end
            end
            // Primitive root search
            esv_pkg::ST_RA:
            begin
                if (a_reg >= p_cfg_reg) stat_next = esv_pkg::STAT_NO_ROOT;
                else                    k_next = '0;
            end
            esv_pkg::ST_RK:
            begin
                if (k_reg == nf_reg)
                begin
                    e1_next      = a_reg;
                    pw_base_next = a_reg;
                    pw_exp_next  = d_cfg_reg;
                    pw_acc_next  = W'(1);
                    ret_next     = esv_pkg::ST_GOT_E2;
                end
                else
                begin
                    req.start = 1'b1;
                    req.b     = nm1;
                    req.n     = fac_k;
                end
            end
            esv_pkg::ST_RDIV:
            begin
                if (rsp.done)
                begin
                    pw_base_next = a_reg;
                    pw_exp_next  = rsp.quot;
                    pw_acc_next  = W'(1);
                    ret_next     = esv_pkg::ST_RTEST;
                end
            end
            esv_pkg::ST_RTEST:
            begin
                if (pw_acc_reg == W'(1)) a_next = a_reg + 1'b1;
                else                     k_next = k_reg + 1'b1;
            end
            // Key and first signature part
            esv_pkg::ST_GOT_E2:
            begin
                e2_next      = pw_acc_reg;
                pw_base_next = e1_reg;
                pw_exp_next  = r_reg;
                pw_acc_next  = W'(1);
                ret_next     = esv_pkg::ST_GOT_S1;
            end
            esv_pkg::ST_GOT_S1:
            begin
                s1_next   = pw_acc_reg;
                req.start = 1'b1;
                req.b     = r_reg;
                req.n     = nm1;
            end
            // Linear search for the nonce inverse
            esv_pkg::ST_RWAIT:
            begin
                if (rsp.done)
                begin
                    rn_next   = rsp.rem;
                    inv_next  = W'(1);
                    prod_next = rsp.rem;
                end
            end
            esv_pkg::ST_INV:
            begin
                if (prod_reg == W'(1))
                begin
                    req.start = 1'b1;
                    req.b     = s1_reg;
                    req.n     = nm1;
                end
                else if (inv_reg == nm1)
                begin
                    stat_next = esv_pkg::STAT_NO_INV;
                end
                else
                begin
                    inv_next  = inv_reg + 1'b1;
                    prod_next = prod_add;
                end
            end
            // Second signature part
            esv_pkg::ST_DM0:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.op    = esv_pkg::OP_MULMOD;
                    req.a     = rsp.rem;
                    req.b     = d_cfg_reg;
                    req.n     = nm1;
                end
            end
            esv_pkg::ST_DM1:
            begin
                if (rsp.done)
                begin
                    tmp_next  = rsp.rem;
                    req.start = 1'b1;
                    req.b     = m_reg;
                    req.n     = nm1;
                end
            end
            esv_pkg::ST_CAL:
            begin
                if (rsp.done)
                begin
                    req.start = 1'b1;
                    req.op    = esv_pkg::OP_MULMOD;
                    req.a     = cal;
                    req.b     = inv_reg;
                    req.n     = nm1;
                end
            end
            esv_pkg::ST_S2:
            begin
                if (rsp.done)
                begin
                    s2_next      = rsp.rem;
                    pw_base_next = e1_reg;
                    pw_exp_next  = m_reg;
                    pw_acc_next  = W'(1);
                    ret_next     = esv_pkg::ST_GOT_V1;
                end
            end
            // Verification
            esv_pkg::ST_GOT_V1:
            begin
                v1_next      = pw_acc_reg;
                pw_base_next = e2_reg;
                pw_exp_next  = s1_reg;
                pw_acc_next  = W'(1);
                ret_next     = esv_pkg::ST_GOT_V2A;
            end
            esv_pkg::ST_GOT_V2A:
            begin
                v2a_next     = pw_acc_reg;
                pw_base_next = s1_reg;
                pw_exp_next  = s2_reg;
                pw_acc_next  = W'(1);
                ret_next     = esv_pkg::ST_GOT_V2B;
            end
            esv_pkg::ST_GOT_V2B:
            begin
                req.start = 1'b1;
                req.op    = esv_pkg::OP_MULMOD;
                req.a     = v2a_reg;
                req.b     = pw_acc_reg;
            end
            esv_pkg::ST_VWAIT:
            begin
                if (rsp.done) ver_next = (rsp.rem == v1_reg);
            end
            // Square-and-multiply, LSB first
            esv_pkg::ST_POW:
            begin
                if (pw_exp_reg != '0)
                begin
                    req.start = 1'b1;
                    req.op    = esv_pkg::OP_MULMOD;
                    req.a     = pw_exp_reg[0] ? pw_acc_reg : pw_base_reg;
                    req.b     = pw_base_reg;
                end
            end
            esv_pkg::ST_PMUL:
            begin
                if (rsp.done)
                begin
                    pw_acc_next = rsp.rem;
                    req.start   = 1'b1;
                    req.op      = esv_pkg::OP_MULMOD;
                    req.a       = pw_base_reg;
                    req.b       = pw_base_reg;
                end
            end
            esv_pkg::ST_PSQ:
            begin
                if (rsp.done)
                begin
                    pw_base_next = rsp.rem;
                    pw_exp_next  = {1'b0, pw_exp_reg[W-1:1]};
                end
            end
            esv_pkg::ST_FINISH:
            begin
                stat_next = stat_reg;
            end
            default:
            begin
                stat_next = stat_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esv_pkg::ST_IDLE;
            ret_reg   <= esv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Factor store
    always_ff @(posedge clk)
    begin
        if (fac_we)
        begin
            fac_reg[nf_reg[esv_pkg::FAC_IDX_BITS-1:0]] <= fac_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        rest_reg    <= rest_next;
        first_reg   <= first_next;
        nf_reg      <= nf_next;
        k_reg       <= k_next;
        a_reg       <= a_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        ver_reg     <= ver_next;
        stat_reg    <= stat_next;
        rn_reg      <= rn_next;
        inv_reg     <= inv_next;
        prod_reg    <= prod_next;
        tmp_reg     <= tmp_next;
        v1_reg      <= v1_next;
        v2a_reg     <= v2a_next;
        pw_base_reg <= pw_base_next;
        pw_exp_reg  <= pw_exp_next;
        pw_acc_reg  <= pw_acc_next;
    end

    // Outputs
    assign busy       = (state_reg != esv_pkg::ST_IDLE);
    assign done       = (state_reg == esv_pkg::ST_FINISH);
    assign generator  = e1_reg;
    assign public_key = e2_reg;
    assign sig_first  = s1_reg;
    assign sig_second = s2_reg;
    assign verified   = ver_reg;
    assign status     = stat_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !rsp.busy)
        else $error("unit request while unit busy");

    a_done_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !rsp.busy)
        else $error("result issued while unit still running");

    a_noroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == esv_pkg::STAT_NO_ROOT) |-> (generator == '0 && verified == 1'b0))
        else $error("no-root result carries data");

endmodule
